// ===== rtl/flam_pkg.sv =====
// Shared constants, types and helper functions for the magazine handle allocator.
package flam_pkg;

	// Pool geometry: handles 0..POOL_SIZE-1, link entries one bit wider for the null marker
	localparam int POOL_SIZE     = 1024;
	localparam int HW            = $clog2(POOL_SIZE);
	localparam int CW            = HW + 1;
	localparam int CNT_W         = 11;
	localparam int MAG_DEPTH_DEF = 32;

	localparam logic [CW-1:0]    NULL_LINK = CW'(POOL_SIZE);
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	localparam logic [10:0]      EPS_RESET = 11'd64;

	// Class of an accepted item
	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_SKIP  = 2'd2
	} op_t;

	typedef struct packed {
		op_t           op;
		logic [HW-1:0] handle;
	} item_t;

	typedef struct packed {
		logic [HW-1:0]    handle;
		logic             status;
		logic [CNT_W-1:0] used;
		logic [CNT_W-1:0] free;
	} res_t;

	// Saturating counter helpers
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
		input logic [CNT_W-1:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, v} + {1'b0, n};
		return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] v);
		return (v == '0) ? '0 : v - 1'b1;
	endfunction

endpackage

// ===== rtl/flam_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module flam_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/flam_front.sv =====
// Front end: accepts items, classifies them and queues them for the engine.
module flam_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic [flam_pkg::HW-1:0] handle_in,
	output logic                   q_valid,
	output flam_pkg::item_t        q_item,
	input  logic                   q_pop
);
	import flam_pkg::*;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	// Classify: frees of handles outside the pool only report counts
	always_comb begin
		cls.handle = handle_in;
		if (!kind) begin
			cls.op = OP_ALLOC;
		end else if ({1'b0, handle_in} < CW'(POOL_SIZE)) begin
			cls.op = OP_FREE;
		end else begin
			cls.op = OP_SKIP;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_ptr_q];

	// Two-entry queue
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ===== rtl/flam_engine.sv =====
// Back end: magazine stack, linked free list walks, slab growth and result register.
module flam_engine #(
	parameter int MAG_DEPTH = flam_pkg::MAG_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [10:0]     eps,
	input  logic            q_valid,
	input  flam_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output flam_pkg::res_t  res
);
	import flam_pkg::*;

	localparam int MA   = $clog2(MAG_DEPTH);
	localparam int FW   = $clog2(MAG_DEPTH + 1);
	localparam int HALF = MAG_DEPTH / 2;
	localparam int GW   = $clog2(HALF + 1);

	typedef enum logic [9:0] {
		S_IDLE        = 10'b0000000001,
		S_REFILL      = 10'b0000000010,
		S_REFILL_WAIT = 10'b0000000100,
		S_GROW        = 10'b0000001000,
		S_POP_RD      = 10'b0000010000,
		S_POP_WAIT    = 10'b0000100000,
		S_FLUSH_RD    = 10'b0001000000,
		S_FLUSH_WR    = 10'b0010000000,
		S_PUSH        = 10'b0100000000,
		S_RESULT      = 10'b1000000000
	} state_t;

	state_t           state_q, state_d;
	item_t            item_q, item_d;
	logic [FW-1:0]    fill_q, fill_d, fill_m1;
	logic [CW-1:0]    head_q, head_d;
	logic [CW-1:0]    carved_q, carved_d;
	logic [CNT_W-1:0] free_q, free_d, used_q, used_d;
	logic [GW-1:0]    got_q, got_d;
	logic [CW-1:0]    gidx_q, gidx_d, gend_q, gend_d, gidx_p1;
	logic [HW-1:0]    hout_q, hout_d;
	logic             status_q, status_d;
	logic             out_valid_q, out_load;
	res_t             res_q;

	logic             mag_we;
	logic [MA-1:0]    mag_waddr, mag_raddr;
	logic [HW-1:0]    mag_wdata, mag_rdata;
	logic             link_we;
	logic [HW-1:0]    link_waddr, link_raddr;
	logic [CW-1:0]    link_wdata, link_rdata;

	logic [CW-1:0]    want, left, grow_n;

	// Magazine stack and next-link store
	flam_ram #(.W(HW), .D(MAG_DEPTH)) u_mag (
		.clk(clk), .we(mag_we), .waddr(mag_waddr), .wdata(mag_wdata),
		.raddr(mag_raddr), .rdata(mag_rdata)
	);

	flam_ram #(.W(CW), .D(POOL_SIZE)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(link_raddr), .rdata(link_rdata)
	);

	// Slab size: zero acts as one, clipped to what is left of the pool
	always_comb begin
		want   = (eps == '0) ? CW'(1) : CW'(eps);
		left   = CW'(POOL_SIZE) - carved_q;
		grow_n = (want < left) ? want : left;
	end

	assign fill_m1  = fill_q - 1'b1;
	assign gidx_p1  = gidx_q + 1'b1;
	assign out_load = (state_q == S_RESULT) && (!out_valid_q || out_ready);

	// Sequencer
	always_comb begin
		state_d    = state_q;
		item_d     = item_q;
		fill_d     = fill_q;
		head_d     = head_q;
		carved_d   = carved_q;
		free_d     = free_q;
		used_d     = used_q;
		got_d      = got_q;
		gidx_d     = gidx_q;
		gend_d     = gend_q;
		hout_d     = hout_q;
		status_d   = status_q;
		q_pop      = 1'b0;
		mag_we     = 1'b0;
		mag_waddr  = fill_q[MA-1:0];
		mag_wdata  = head_q[HW-1:0];
		mag_raddr  = fill_m1[MA-1:0];
		link_we    = 1'b0;
		link_waddr = gidx_q[HW-1:0];
		link_wdata = (gidx_p1 == gend_q) ? NULL_LINK : gidx_p1;
		link_raddr = head_q[HW-1:0];

		unique case (state_q)
			S_IDLE: begin
				hout_d   = '0;
				status_d = 1'b0;
				if (q_valid) begin
					q_pop  = 1'b1;
					item_d = q_item;
					got_d  = '0;
					case (q_item.op)
						OP_ALLOC: state_d = (fill_q == '0) ? S_REFILL : S_POP_RD;
						OP_FREE:  state_d = (fill_q == FW'(MAG_DEPTH)) ? S_FLUSH_RD : S_PUSH;
						default:  state_d = S_RESULT;
					endcase
				end
			end
			S_REFILL: begin
				if (got_q == GW'(HALF) ||
					(head_q == NULL_LINK && carved_q == CW'(POOL_SIZE))) begin
					// Refill over, possibly part way
					if (fill_q == '0) begin
						status_d = 1'b1;
						state_d  = S_RESULT;
					end else begin
						state_d = S_POP_RD;
					end
				end else if (head_q == NULL_LINK) begin
					gidx_d  = carved_q;
					gend_d  = carved_q + grow_n;
					state_d = S_GROW;
				end else begin
					mag_we  = 1'b1;
					fill_d  = fill_q + 1'b1;
					free_d  = sat_dec(free_q);
					used_d  = sat_add(used_q, CNT_W'(1));
					got_d   = got_q + 1'b1;
					state_d = S_REFILL_WAIT;
				end
			end
			S_REFILL_WAIT: begin
				head_d  = link_rdata;
				state_d = S_REFILL;
			end
			S_GROW: begin
				// Chain new handles in ascending order, last one to null
				link_we = 1'b1;
				gidx_d  = gidx_p1;
				if (gidx_p1 == gend_q) begin
					head_d   = carved_q;
					carved_d = gend_q;
					free_d   = sat_add(free_q, CNT_W'(gend_q - carved_q));
					state_d  = S_REFILL;
				end
			end
			S_POP_RD: begin
				fill_d  = fill_m1;
				state_d = S_POP_WAIT;
			end
			S_POP_WAIT: begin
				hout_d  = mag_rdata;
				state_d = S_RESULT;
			end
			S_FLUSH_RD: begin
				if (got_q == GW'(HALF)) begin
					state_d = S_PUSH;
				end else begin
					fill_d  = fill_m1;
					state_d = S_FLUSH_WR;
				end
			end
			S_FLUSH_WR: begin
				// Push the magazine top back onto the list head
				link_we    = 1'b1;
				link_waddr = mag_rdata;
				link_wdata = head_q;
				head_d     = {1'b0, mag_rdata};
				free_d     = sat_add(free_q, CNT_W'(1));
				used_d     = sat_dec(used_q);
				got_d      = got_q + 1'b1;
				state_d    = S_FLUSH_RD;
			end
			S_PUSH: begin
				mag_we    = 1'b1;
				mag_wdata = item_q.handle;
				fill_d    = fill_q + 1'b1;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
		got_q  <= got_d;
		gidx_q <= gidx_d;
		gend_q <= gend_d;
		hout_q <= hout_d;
		status_q <= status_d;
		if (out_load) begin
			res_q.handle <= hout_q;
			res_q.status <= status_q;
			res_q.used   <= used_q;
			res_q.free   <= free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			head_q      <= NULL_LINK;
			carved_q    <= '0;
			free_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			head_q   <= head_d;
			carved_q <= carved_d;
			free_q   <= free_d;
			used_q   <= used_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/free_list_allocator_with_magazine_unit.sv =====
// Top level of the two-level handle allocator: front queue, engine and slab size register.
// Handles come from a fixed pool of 1024, carved into a linked free list one slab
// (elements_per_slab handles, 0 taken as 1) at a time and cached in a magazine stack of
// MAG_DEPTH entries. Each item gives one result. An allocate from a non-empty magazine
// issues the magazine RAM read, waits for its registered data, then loads the result;
// a plain free writes the handle into the magazine, then loads the result. An empty
// magazine first refills up to MAG_DEPTH/2 handles, one link RAM read per handle, and
// grows a slab, one handle at a time, whenever the free list runs dry; a free into a
// full magazine first flushes MAG_DEPTH/2 entries back onto the list. A two-item queue in
// front and a one-item result register behind let input and output stall independently.
// Status 1 on an allocate means the pool is exhausted. No clearing pass after reset.
module free_list_allocator_with_magazine_unit #(
	parameter int MAG_DEPTH = flam_pkg::MAG_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [10:0]               cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      kind,
	input  logic [flam_pkg::HW-1:0]    handle_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [flam_pkg::HW-1:0]    handle_out,
	output logic                      status,
	output logic [flam_pkg::CNT_W-1:0] used_count,
	output logic [flam_pkg::CNT_W-1:0] free_count
);
	import flam_pkg::*;

	logic        q_valid, q_pop;
	item_t       q_item;
	res_t        res;
	logic [10:0] eps_q;

	// Slab size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_wen) begin
			eps_q <= cfg_wdata;
		end
	end

	flam_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .handle_in(handle_in),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	flam_engine #(.MAG_DEPTH(MAG_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .eps(eps_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign handle_out = res.handle;
	assign status     = res.status;
	assign used_count = res.used;
	assign free_count = res.free;

endmodule

// ===== rtl/flam_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
module flam_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [flam_pkg::HW-1:0]    handle_out,
	input logic                      status
);

	logic [2:0] outst_q;
	logic       acc_in, acc_out;

	assign acc_in  = in_valid && in_ready;
	assign acc_out = out_valid && out_ready;

	// Items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= 3'd0;
		end else begin
			outst_q <= outst_q + {2'b0, acc_in} - {2'b0, acc_out};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> handle_out == '0)
		else $error("failed allocate carries a handle");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outst_q != 3'd0)
		else $error("result item without an accepted item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= 3'd4)
		else $error("more items in flight than the block can hold");

endmodule

bind free_list_allocator_with_magazine_unit flam_checker u_flam_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .handle_out(handle_out),
	.status(status)
);

// ===== bench/free_list_allocator_with_magazine_unit_tb.sv =====
// Self-checking bench for the magazine handle allocator: directed table, then random phases.
module free_list_allocator_with_magazine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import flam_pkg::*;

	localparam int MAG       = 32;
	localparam int HALF      = MAG / 2;
	localparam int IDLE_LIMIT = 40000;

	logic             clk;
	logic             arst_n;
	logic             cfg_wen;
	logic [10:0]      cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	logic             kind;
	logic [HW-1:0]    handle_in;
	logic             out_valid;
	logic             out_ready;
	logic [HW-1:0]    handle_out;
	logic             status;
	logic [CNT_W-1:0] used_count;
	logic [CNT_W-1:0] free_count;

	free_list_allocator_with_magazine_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind), .handle_in(handle_in),
		.out_valid(out_valid), .out_ready(out_ready), .handle_out(handle_out),
		.status(status), .used_count(used_count), .free_count(free_count)
	);

	// Shadow allocator state
	logic [CW-1:0] link_mem [POOL_SIZE];
	logic [HW-1:0] mag_mem [MAG];
	int            head, carved, fill, n_free, n_used, slab_len;

	res_t          pending_q [$];
	logic [HW-1:0] held_q [$];
	int            errs;
	int            send_idle, recv_stall;
	int            quiet_cycles;

	typedef struct {
		logic          k;
		logic [HW-1:0] h;
		bit            typed;
		res_t          r;
	} row_t;
	row_t rows [$];

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic int clamp_cnt(input int v);
		return (v > 2047) ? 2047 : ((v < 0) ? 0 : v);
	endfunction

	// Carve one slab onto the head of the free list, lowest handle first
	task automatic carve_slab();
		int want, n, hh;
		want = (slab_len == 0) ? 1 : slab_len;
		n = (want < POOL_SIZE - carved) ? want : POOL_SIZE - carved;
		for (int i = n; i > 0; i--) begin
			hh = carved + i - 1;
			link_mem[hh] = CW'(head);
			head = hh;
		end
		carved += n;
		n_free = clamp_cnt(n_free + n);
	endtask

	// Work out the result of one item and update the shadow state
	task automatic predict_alloc(input logic k, input logic [HW-1:0] h, output res_t r);
		r = '0;
		if (k == 1'b0) begin
			if (fill == 0) begin
				for (int got = 0; got < HALF && fill < MAG; got++) begin
					if (head >= POOL_SIZE) carve_slab();
					if (head >= POOL_SIZE) break;
					mag_mem[fill] = HW'(head);
					fill++;
					head = link_mem[head];
					n_free = clamp_cnt(n_free - 1);
					n_used = clamp_cnt(n_used + 1);
				end
			end
			if (fill == 0) begin
				r.status = 1'b1;
			end else begin
				fill--;
				r.handle = mag_mem[fill];
			end
		end else begin
			if (fill >= MAG) begin
				for (int i = 0; i < HALF && fill > 0; i++) begin
					fill--;
					link_mem[mag_mem[fill]] = CW'(head);
					head = mag_mem[fill];
					n_free = clamp_cnt(n_free + 1);
					n_used = clamp_cnt(n_used - 1);
				end
			end
			mag_mem[fill] = h;
			fill++;
		end
		r.used = CNT_W'(n_used);
		r.free = CNT_W'(n_free);
	endtask

	// Present one item and hold it until accepted; queue its expectation
	task automatic send_item(input logic k, input logic [HW-1:0] h, input bit typed,
		input res_t typed_r);
		res_t r;
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		handle_in <= h;
		do @(posedge clk); while (!(in_valid && in_ready));
		predict_alloc(k, h, r);
		if (k == 1'b0 && r.status == 1'b0) held_q.push_back(r.handle);
		pending_q.push_back(typed ? typed_r : r);
	endtask

	// Wait for every result, let the engine settle, then write the slab size
	task automatic drain_and_config(input logic [10:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		slab_len = v;
	endtask

	// Receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// Result checker
	always @(posedge clk) begin
		res_t e;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("result with nothing expected: handle_out %0d", handle_out);
				errs++;
			end else begin
				e = pending_q.pop_front();
				if (handle_out !== e.handle) begin
					$error("handle_out expected %0d got %0d", e.handle, handle_out);
					errs++;
				end
				if (status !== e.status) begin
					$error("status expected %0d got %0d", e.status, status);
					errs++;
				end
				if (used_count !== e.used) begin
					$error("used_count expected %0d got %0d", e.used, used_count);
					errs++;
				end
				if (free_count !== e.free) begin
					$error("free_count expected %0d got %0d", e.free, free_count);
					errs++;
				end
			end
		end
	end

	// Watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int      n_items, alloc_pct, idx;
		int      phase_items [4]  = '{450, 350, 800, 350};
		int      phase_alloc [4]  = '{85, 50, 97, 40};
		int      phase_send  [4]  = '{0, 69, 0, 20};
		int      phase_recv  [4]  = '{0, 0, 69, 20};
		logic [10:0] phase_slab [4] = '{11'd0, 11'd2047, 11'd1, 11'd1024};
		logic [HW-1:0] h;
		row_t    rw;

		errs = 0; quiet_cycles = 0;
		send_idle = 0; recv_stall = 0;
		arst_n = 1'b0; cfg_wen = 1'b0; cfg_wdata = '0;
		in_valid = 1'b0; kind = 1'b0; handle_in = '0; out_ready = 1'b0;
		head = POOL_SIZE; carved = 0; fill = 0; n_free = 0; n_used = 0; slab_len = 64;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		drain_and_config(11'd64);

		// Directed table: first allocate carves 64 and refills 16, top is handle 15
		rw = '{1'b0, 10'd0,    1'b1, '{10'd15,   1'b0, 11'd16, 11'd48}}; rows.push_back(rw);
		rw = '{1'b1, 10'd1023, 1'b1, '{10'd0,    1'b0, 11'd16, 11'd48}}; rows.push_back(rw);
		rw = '{1'b0, 10'd1023, 1'b1, '{10'd1023, 1'b0, 11'd16, 11'd48}}; rows.push_back(rw);
		rw = '{1'b1, 10'd0,    1'b0, '0}; rows.push_back(rw);
		rw = '{1'b1, 10'd682,  1'b0, '0}; rows.push_back(rw);
		rw = '{1'b1, 10'd341,  1'b0, '0}; rows.push_back(rw);
		// fill the magazine and push once more to force a flush
		for (int i = 0; i < 15; i++) begin
			rw = '{1'b1, 10'(100 + i * 37), 1'b0, '0}; rows.push_back(rw);
		end
		for (int i = 0; i < 4; i++) begin
			rw = '{1'b0, 10'd1023, 1'b0, '0}; rows.push_back(rw);
		end
		foreach (rows[i]) send_item(rows[i].k, rows[i].h, rows[i].typed, rows[i].r);

		// Random phases with differing slab sizes and idling
		for (int p = 0; p < 4; p++) begin
			drain_and_config(phase_slab[p]);
			send_idle  = phase_send[p];
			recv_stall = phase_recv[p];
			n_items    = phase_items[p];
			alloc_pct  = phase_alloc[p];
			for (int n = 0; n < n_items; n++) begin
				if ($urandom_range(99) < alloc_pct) begin
					send_item(1'b0, HW'($urandom), 1'b0, '0);
				end else begin
					if (held_q.size() > 0 && $urandom_range(99) < 85) begin
						idx = $urandom_range(held_q.size() - 1);
						h = held_q[idx];
						held_q.delete(idx);
					end else begin
						h = HW'($urandom_range(POOL_SIZE - 1));
					end
					send_item(1'b1, h, 1'b0, '0);
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errs == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/flam_pkg.sv
rtl/flam_ram.sv
rtl/flam_front.sv
rtl/flam_engine.sv
rtl/free_list_allocator_with_magazine_unit.sv
rtl/flam_checker.sv
bench/free_list_allocator_with_magazine_unit_tb.sv
